// ===== rtl/command_response_tracker_core_macros.svh =====
// Assertion macros for the command/response tracker.
`ifndef COMMAND_RESPONSE_TRACKER_CORE_MACROS_SVH
`define COMMAND_RESPONSE_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, idle during reset.
`define CRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker check failed");

// Next-cycle implication, idle during reset.
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker check failed");

`else

`define CRT_ASSERT_NOW(label, clk, rst, ante, cons)
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/crt_pkg.sv =====
// Types and constants shared by the command/response tracker modules.
`timescale 1ns / 1ps

package crt_pkg;

  localparam int unsigned LEN_W     = 16;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned TMO_W     = 16;

  localparam logic [LEN_W-1:0]     SEND_MIN_LEN  = 16'd9;
  localparam logic [LEN_W-1:0]     REPLY_MIN_LEN = 16'd10;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;

  localparam logic [TYPE_W-1:0] CODE_ACK_A = 8'hBB;
  localparam logic [TYPE_W-1:0] CODE_ACK_B = 8'hCC;
  localparam logic [TYPE_W-1:0] CODE_FIN_A = 8'h33;
  localparam logic [TYPE_W-1:0] CODE_FIN_B = 8'h55;

  localparam logic [TMO_W-1:0] ACK_TMO_RESET  = 16'd1000;
  localparam logic [TMO_W-1:0] EXEC_TMO_RESET = 16'd5000;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_NONE    = 3'd0,
    PH_SENT    = 3'd1,
    PH_ACKED   = 3'd2,
    PH_DONE    = 3'd3,
    PH_TIMEOUT = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    EV_ACCEPTED      = 4'd0,
    EV_SEND_SHORT    = 4'd1,
    EV_BUSY          = 4'd2,
    EV_ACKED         = 4'd3,
    EV_FINISHED      = 4'd4,
    EV_IDLE          = 4'd5,
    EV_REPLY_SHORT   = 4'd6,
    EV_TYPE_MISMATCH = 4'd7,
    EV_UNKNOWN_CODE  = 4'd8,
    EV_ACK_TIMEOUT   = 4'd9,
    EV_EXEC_TIMEOUT  = 4'd10,
    EV_NOTHING       = 4'd11,
    EV_EMPTY         = 4'd12
  } event_t;

  // Register indexes on the configuration port.
  localparam logic REG_ACK_TMO  = 1'b0;
  localparam logic REG_EXEC_TMO = 1'b1;

  typedef struct packed {
    cmd_t              command;
    logic [LEN_W-1:0]  frame_length;
    logic [TYPE_W-1:0] frame_type;
    logic [TYPE_W-1:0] reply_code;
  } item_t;

  typedef struct packed {
    event_t event_code;
    phase_t phase;
    logic   pending;
  } res_t;

endpackage

// ===== rtl/crt_in_reg.sv =====
// Input register stage for incoming item beats.
`timescale 1ns / 1ps

module crt_in_reg
  import crt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  vld,
  input  logic  take,
  output item_t item
);

  assign in_ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/crt_engine.sv =====
// Tracker state and per-item event decode.
`timescale 1ns / 1ps

module crt_engine
  import crt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  item_t            item,
  input  logic [TMO_W-1:0] ack_tmo,
  input  logic [TMO_W-1:0] exec_tmo,
  output res_t             res
);

  phase_t               phase, phase_next;
  logic                 pending, pending_next;
  logic [TYPE_W-1:0]    sent_type, sent_type_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next, elapsed_inc;
  event_t               ev;
  logic                 is_ack, is_fin;

  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign is_ack = (item.reply_code == CODE_ACK_A) || (item.reply_code == CODE_ACK_B);
  assign is_fin = (item.reply_code == CODE_FIN_A) || (item.reply_code == CODE_FIN_B);

  // event decode
  always_comb begin
    ev = EV_NOTHING;
    unique case (item.command)
      CMD_SEND: begin
        if (item.frame_length < SEND_MIN_LEN) ev = EV_SEND_SHORT;
        else if (pending)                     ev = EV_BUSY;
        else                                  ev = EV_ACCEPTED;
      end
      CMD_REPLY: begin
        if (!pending)                              ev = EV_IDLE;
        else if (item.frame_length == '0)          ev = EV_EMPTY;
        else if (item.frame_length < REPLY_MIN_LEN) ev = EV_REPLY_SHORT;
        else if (item.frame_type != sent_type)     ev = EV_TYPE_MISMATCH;
        else if (is_ack)                           ev = EV_ACKED;
        else if (is_fin)                           ev = EV_FINISHED;
        else                                       ev = EV_UNKNOWN_CODE;
      end
      CMD_TICK: begin
        if (pending && phase == PH_SENT &&
            elapsed_inc > {1'b0, ack_tmo}) begin
          ev = EV_ACK_TIMEOUT;
        end else if (pending && phase == PH_ACKED &&
                     elapsed_inc > {1'b0, exec_tmo}) begin
          ev = EV_EXEC_TIMEOUT;
        end else begin
          ev = EV_NOTHING;
        end
      end
      CMD_NOP: ev = EV_NOTHING;
      default: ev = EV_NOTHING;
    endcase
  end

  // next state from the decoded event
  always_comb begin
    phase_next     = phase;
    pending_next   = pending;
    sent_type_next = sent_type;
    elapsed_next   = (item.command == CMD_TICK) ? elapsed_inc : elapsed;
    unique case (ev)
      EV_ACCEPTED: begin
        phase_next     = PH_SENT;
        pending_next   = 1'b1;
        sent_type_next = item.frame_type;
        elapsed_next   = '0;
      end
      EV_ACKED:    phase_next = PH_ACKED;
      EV_FINISHED: begin
        phase_next   = PH_DONE;
        pending_next = 1'b0;
      end
      EV_ACK_TIMEOUT, EV_EXEC_TIMEOUT: begin
        phase_next   = PH_TIMEOUT;
        pending_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NONE;
      pending   <= 1'b0;
      sent_type <= '0;
      elapsed   <= '0;
    end else if (take) begin
      phase     <= phase_next;
      pending   <= pending_next;
      sent_type <= sent_type_next;
      elapsed   <= elapsed_next;
    end
  end

  assign res.event_code = ev;
  assign res.phase      = phase_next;
  assign res.pending    = pending_next;

endmodule

// ===== rtl/crt_out_reg.sv =====
// Result register stage for outgoing beats.
`timescale 1ns / 1ps

module crt_out_reg
  import crt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/command_response_tracker_core.sv =====
// Top level of the command/response tracker with its register port.
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   s_tuser command, s_tdata frame fields
//  m_*      out  m_tvalid / m_tready   m_tdata event, phase, pending
//  apb      in   psel,penable,pwrite   paddr/pwdata -> timeout registers
//
// One beat per cycle unless m_tready stalls: input register, one pass of
// compare and counter logic, result register. m_tvalid rises once the result
// register is loaded. A held result freezes the engine; the empty input
// register still takes one more beat, then s_tready stays low until m_tready
// frees the result slot (s_tready follows m_tready combinationally).
// rst (synchronous) clears the tracker to idle and timeouts to 1000/5000 ms.
`timescale 1ns / 1ps
`include "command_response_tracker_core_macros.svh"

module command_response_tracker_core
  import crt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] frame_length, [23:16] frame_type,
                                 // [31:24] reply_code
  input  logic [1:0]  s_tuser,   // [1:0] command
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] event_code, [6:4] phase, [7] pending
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TMO_W-1:0] ack_tmo, exec_tmo;
  logic             cfg_wr;
  item_t            s_item, item;
  logic             item_vld, can_load, take;
  res_t             res, res_out;

  // register port: two timeouts, word addressed, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_tmo  <= ACK_TMO_RESET;
      exec_tmo <= EXEC_TMO_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ACK_TMO:  ack_tmo  <= pwdata[TMO_W-1:0];
        REG_EXEC_TMO: exec_tmo <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACK_TMO:  prdata = {16'd0, ack_tmo};
      REG_EXEC_TMO: prdata = {16'd0, exec_tmo};
      default:      prdata = '0;
    endcase
  end

  // unpack the input beat
  assign s_item.command      = cmd_t'(s_tuser);
  assign s_item.frame_length = s_tdata[15:0];
  assign s_item.frame_type   = s_tdata[23:16];
  assign s_item.reply_code   = s_tdata[31:24];

  crt_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (s_item),
    .vld      (item_vld),
    .take     (take),
    .item     (item)
  );

  // an item is evaluated and the state moves only when the result has a slot
  assign take = item_vld && can_load;

  crt_engine u_eng (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .ack_tmo  (ack_tmo),
    .exec_tmo (exec_tmo),
    .res      (res)
  );

  crt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_out)
  );

  assign m_tdata = {res_out.pending, res_out.phase, res_out.event_code};

  // a pending command is always in the sent or acknowledged phase
  `CRT_ASSERT_NOW(a_pend_phase, clk, rst, m_tvalid && res_out.pending, res_out.phase == PH_SENT || res_out.phase == PH_ACKED)
  // every evaluated item shows up as a result on the next cycle
  `CRT_ASSERT_NEXT(a_take_out, clk, rst, take, m_tvalid)
  // an accepted send always reports the sent phase with pending set
  `CRT_ASSERT_NOW(a_accept_sent, clk, rst, m_tvalid && res_out.event_code == EV_ACCEPTED, res_out.phase == PH_SENT && res_out.pending)
  // a write to the acknowledge timeout lands in the register
  `CRT_ASSERT_NEXT(a_cfg_ack, clk, rst, cfg_wr && paddr[2] == REG_ACK_TMO, ack_tmo == $past(pwdata[TMO_W-1:0]))

endmodule

// ===== tb/sv/tb_command_response_tracker_core.sv =====
// Self-checking testbench for the command/response tracker: directed and random beats.
`timescale 1ns / 1ps

module tb_command_response_tracker_core;
  import crt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;  // far above the slowest passing run
  localparam int unsigned BEATS_PER_SETTING = 145;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] frame_length, [23:16] frame_type, [31:24] reply_code
  logic [1:0]  s_tuser = '0;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [3:0] event_code, [6:4] phase, [7] pending
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  command_response_tracker_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Beats waiting to go in, and tracker outcomes waiting to come out.
  item_t tracker_items[$];
  res_t  expected_results[$];

  // Own copy of the tracker: timeouts plus the four state registers.
  logic [TMO_W-1:0]     ack_limit  = ACK_TMO_RESET;
  logic [TMO_W-1:0]     exec_limit = EXEC_TMO_RESET;
  phase_t               trk_phase   = PH_NONE;
  logic                 trk_pending = 1'b0;
  logic [TYPE_W-1:0]    trk_type    = '0;
  logic [ELAPSED_W-1:0] trk_elapsed = '0;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 51;
  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned timeouts_seen = 0;
  int unsigned settings_run = 0;

  item_t cur_beat;
  logic  in_beat;
  logic  load_next;
  res_t  want;

  initial begin
    forever #5 clk = ~clk;
  end

  // Next tracker outcome for one accepted beat; updates the tracker copy.
  function automatic res_t track_step(input item_t it);
    event_t ev;
    res_t   r;
    ev = EV_NOTHING;
    case (it.command)
      CMD_SEND: begin
        if (it.frame_length < SEND_MIN_LEN) begin
          ev = EV_SEND_SHORT;        // length check wins over busy
        end else if (trk_pending) begin
          ev = EV_BUSY;
        end else begin
          trk_type    = it.frame_type;
          trk_elapsed = '0;
          trk_phase   = PH_SENT;
          trk_pending = 1'b1;
          ev = EV_ACCEPTED;
        end
      end
      CMD_REPLY: begin
        if (!trk_pending) begin
          ev = EV_IDLE;
        end else if (it.frame_length == '0) begin
          ev = EV_EMPTY;
        end else if (it.frame_length < REPLY_MIN_LEN) begin
          ev = EV_REPLY_SHORT;
        end else if (it.frame_type != trk_type) begin
          ev = EV_TYPE_MISMATCH;
        end else if (it.reply_code == CODE_ACK_A || it.reply_code == CODE_ACK_B) begin
          trk_phase = PH_ACKED;      // repeat acks leave the timer running
          ev = EV_ACKED;
        end else if (it.reply_code == CODE_FIN_A || it.reply_code == CODE_FIN_B) begin
          trk_phase   = PH_DONE;
          trk_pending = 1'b0;
          ev = EV_FINISHED;
        end else begin
          ev = EV_UNKNOWN_CODE;
        end
      end
      CMD_TICK: begin
        // counter runs even when idle, and sticks at full scale
        if (trk_elapsed != ELAPSED_MAX) trk_elapsed = trk_elapsed + 1'b1;
        if (trk_pending && trk_phase == PH_SENT && trk_elapsed > {1'b0, ack_limit}) begin
          trk_phase   = PH_TIMEOUT;
          trk_pending = 1'b0;
          ev = EV_ACK_TIMEOUT;
        end else if (trk_pending && trk_phase == PH_ACKED &&
                     trk_elapsed > {1'b0, exec_limit}) begin
          trk_phase   = PH_TIMEOUT;
          trk_pending = 1'b0;
          ev = EV_EXEC_TIMEOUT;
        end
      end
      default: ev = EV_NOTHING;     // spare command code: no-op
    endcase
    r.event_code = ev;
    r.phase      = trk_phase;
    r.pending    = trk_pending;
    return r;
  endfunction

  task automatic push_beat(input logic [1:0] cmd, input logic [15:0] len,
                           input logic [7:0] ftype, input logic [7:0] code);
    item_t it;
    it.command      = cmd_t'(cmd);
    it.frame_length = len;
    it.frame_type   = ftype;
    it.reply_code   = code;
    tracker_items.push_back(it);
  endtask

  // Mostly well-formed send/ack/finish exchanges with random content and tick
  // runs of up to 40 ticks, or three past a lower limit; the rest is raw noise.
  task automatic add_random(input int unsigned n);
    int unsigned made;
    int unsigned ack_span;
    int unsigned exec_span;
    int unsigned k;
    logic [7:0]  t;
    made = 0;
    ack_span  = (ack_limit < 40)  ? ack_limit + 3  : 40;
    exec_span = (exec_limit < 40) ? exec_limit + 3 : 40;
    while (made < n) begin
      if ($urandom_range(99) < 25) begin
        push_beat(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom), 8'($urandom));
        made++;
      end else begin
        t = 8'($urandom);
        push_beat(CMD_SEND, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(9, 80)),
                  t, 8'($urandom));
        made++;
        k = $urandom_range(0, ack_span);
        repeat (k) push_beat(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
        made += k;
        if ($urandom_range(9) == 0) begin
          // extra reply, mostly broken: short, empty or wrong type
          push_beat(CMD_REPLY, 16'($urandom_range(0, 12)),
                    ($urandom_range(1) == 0) ? t : t ^ 8'h01, 8'($urandom));
          made++;
        end
        if ($urandom_range(9) < 8) begin
          push_beat(CMD_REPLY, 16'($urandom_range(10, 600)), t,
                    ($urandom_range(1) == 0) ? CODE_ACK_A : CODE_ACK_B);
          made++;
        end
        k = $urandom_range(0, exec_span);
        repeat (k) push_beat(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
        made += k;
        if ($urandom_range(9) < 7) begin
          push_beat(CMD_REPLY, 16'($urandom_range(10, 600)), t,
                    ($urandom_range(1) == 0) ? CODE_FIN_A : CODE_FIN_B);
          made++;
        end
      end
    end
  endtask

  // Setup then access phase; pready is tied high, so the access phase has no wait states.
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [TMO_W-1:0] value);
    logic [31:0] rd;
    apb_access(1'b0, {idx, 2'b00}, '0, rd);
    if (rd !== {16'd0, value}) begin
      $error("register %0d expected %0d got %0d", idx, value, rd);
      mismatches++;
    end
  endtask

  task automatic set_timeouts(input logic [TMO_W-1:0] ack_ms, input logic [TMO_W-1:0] exec_ms);
    logic [31:0] rd;
    apb_access(1'b1, {REG_ACK_TMO, 2'b00}, {16'd0, ack_ms}, rd);
    ack_limit = ack_ms;
    apb_access(1'b1, {REG_EXEC_TMO, 2'b00}, {16'd0, exec_ms}, rd);
    exec_limit = exec_ms;
    check_reg(REG_ACK_TMO, ack_ms);
    check_reg(REG_EXEC_TMO, exec_ms);
  endtask

  // Block is idle once nothing is queued, held or outstanding.
  task automatic drain;
    do @(negedge clk);
    while (tracker_items.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  // Driver: predict on each accepted beat, then load the next one unless idling.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      in_beat = s_tvalid && s_tready;
      if (in_beat) begin
        expected_results.push_back(track_step(cur_beat));
      end
      if (!s_tvalid || in_beat) begin
        load_next = tracker_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (load_next) begin
          cur_beat = tracker_items.pop_front();
          s_tdata <= {cur_beat.reply_code, cur_beat.frame_type, cur_beat.frame_length};
          s_tuser <= cur_beat.command;
        end
        s_tvalid <= load_next;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat %h with nothing expected", m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        beats_checked++;
        if (want.event_code == EV_ACK_TIMEOUT || want.event_code == EV_EXEC_TIMEOUT)
          timeouts_seen++;
        if (m_tdata[3:0] !== want.event_code) begin
          $error("event_code expected %0d got %0d", want.event_code, m_tdata[3:0]);
          mismatches++;
        end
        if (m_tdata[6:4] !== want.phase) begin
          $error("phase expected %0d got %0d", want.phase, m_tdata[6:4]);
          mismatches++;
        end
        if (m_tdata[7] !== want.pending) begin
          $error("pending expected %0d got %0d", want.pending, m_tdata[7]);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    logic [TMO_W-1:0] ack_set [6];
    logic [TMO_W-1:0] exec_set [6];
    ack_set  = '{16'd3, 16'd0, 16'd65535, 16'd12, 16'd1, 16'd65535};
    exec_set = '{16'd8, 16'd0, 16'd65535, 16'd4, 16'd65535, 16'd0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values of both timeouts
    check_reg(REG_ACK_TMO, ACK_TMO_RESET);
    check_reg(REG_EXEC_TMO, EXEC_TMO_RESET);

    // Directed: short limits so timeouts come within a few ticks.
    set_timeouts(16'd2, 16'd3);
    @(negedge clk);
    push_beat(CMD_REPLY, 16'hFFFF, 8'hA5, CODE_ACK_A);  // reply while idle
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);             // tick while idle
    push_beat(CMD_NOP, 16'hFFFF, 8'hFF, 8'hFF);         // spare command
    push_beat(CMD_SEND, 16'd8, 8'hA5, 8'd0);            // one byte too short
    push_beat(CMD_SEND, 16'd9, 8'hA5, 8'd0);            // shortest accepted
    push_beat(CMD_SEND, 16'hFFFF, 8'h11, 8'd0);         // busy
    push_beat(CMD_SEND, 16'd3, 8'h11, 8'd0);            // short beats busy
    push_beat(CMD_REPLY, 16'd0, 8'hA5, CODE_FIN_A);     // nothing read
    push_beat(CMD_REPLY, 16'd9, 8'hA5, CODE_FIN_A);     // reply too short
    push_beat(CMD_REPLY, 16'd10, 8'h5A, CODE_ACK_A);    // wrong type
    push_beat(CMD_REPLY, 16'd10, 8'hA5, 8'h00);         // unknown code
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);
    push_beat(CMD_REPLY, 16'd10, 8'hA5, CODE_ACK_A);
    push_beat(CMD_REPLY, 16'hFFFF, 8'hA5, CODE_ACK_B);  // repeat ack, timer kept
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);             // exec timeout, counted from send
    push_beat(CMD_SEND, 16'hFFFF, 8'hFF, 8'hFF);
    push_beat(CMD_REPLY, 16'd10, 8'hFF, CODE_FIN_A);
    push_beat(CMD_SEND, 16'd9, 8'h00, 8'd0);
    push_beat(CMD_REPLY, 16'hFFFF, 8'h00, CODE_FIN_B);
    push_beat(CMD_SEND, 16'd9, 8'h3C, 8'd0);
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);
    push_beat(CMD_TICK, 16'd0, 8'd0, 8'd0);             // ack timeout
    drain();

    // Random phases: idling swaps after the first third, the last third runs flat out.
    for (int i = 0; i < 6; i++) begin
      if (i == 2) begin
        send_idle_pct = 51;
        recv_idle_pct = 29;
      end else if (i == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_timeouts(ack_set[i], exec_set[i]);
      @(negedge clk);
      add_random(BEATS_PER_SETTING);
      drain();
      settings_run++;
    end

    // catch any stray result beat after the last one expected
    repeat (8) @(posedge clk);
    $display("covered %0d result beats over %0d random timeout settings plus directed beats",
             beats_checked, settings_run);
    $display("timeouts fired: %0d, mismatches: %0d", timeouts_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
